FILE: rtl/core/wall_texture_column_mapper_top_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the wall texture column mapper
// ---------------------------------------------------------------------------
`ifndef WALL_TEXTURE_COLUMN_MAPPER_TOP_DEFINES_SVH
`define WALL_TEXTURE_COLUMN_MAPPER_TOP_DEFINES_SVH

// same-cycle implication
`define WTCM_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: check failed");

// next-cycle implication
`define WTCM_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");

`endif

FILE: rtl/core/wtcm_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wtcm_pkg
// Shared types and constants of the wall texture column mapper.
// ---------------------------------------------------------------------------
package wtcm_pkg;

   localparam logic [1:0] CMD_LOAD  = 2'd0;
   localparam logic [1:0] CMD_START = 2'd1;
   localparam logic [1:0] CMD_PIXEL = 2'd2;

   localparam logic [1:0] FACE_NORTH = 2'd0;
   localparam logic [1:0] FACE_SOUTH = 2'd1;
   localparam logic [1:0] FACE_WEST  = 2'd2;
   localparam logic [1:0] FACE_EAST  = 2'd3;

   localparam int unsigned FACE_COUNT = 4;
   localparam int unsigned FACE_W     = 2;

   localparam logic [23:0] SHADE_MASK     = 24'h7F7F7F;
   localparam logic [10:0] WINDOW_DEFAULT = 11'd480;

   typedef struct packed {
      logic [1:0]  command;
      logic [1:0]  face_select;
      logic [11:0] texel_address;
      logic [23:0] texel_color;
      logic        hit_side;
      logic        dir_x_negative;
      logic        dir_y_positive;
      logic [15:0] wall_fraction;
      logic [15:0] slice_height;
      logic [10:0] span_first;
      logic [10:0] span_stop;
      logic [11:0] screen_column;
   } req_type;

   typedef struct packed {
      logic [10:0] pixel_row;
      logic [11:0] pixel_column;
      logic [23:0] pixel_color;
      logic        write_enable;
      logic        last_pixel;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_DIVIDE = 3'b010,
      ST_MULT   = 3'b100
   } state_type;

endpackage

FILE: rtl/core/wall_texture_column_mapper_top.sv
// Load and pixel words: one per cycle while idle and the pixel stage can move; a
// pixel word is registered at the texture memory read, then in the output register.
// Column start: TEX_SIZE over the slice height runs through a restoring divider,
// one quotient bit per cycle, then a multiply step; no next word is taken until
// both are done. Synchronous reset clears control state and
// sets window_height to 480; texture memory is not cleared.
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wall_texture_column_mapper_top
// Texture lookup and shading for one raycast wall column.
// ---------------------------------------------------------------------------
`include "wall_texture_column_mapper_top_defines.svh"

module wall_texture_column_mapper_top #(
   parameter int unsigned TEX_SIZE = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  wtcm_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output wtcm_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [10:0]      csr_data
);
   import wtcm_pkg::*;

   localparam int unsigned TW     = $clog2(TEX_SIZE);
   localparam int unsigned AREA_W = 2 * TW;
   localparam int unsigned ADDR_W = FACE_W + AREA_W;
   localparam int unsigned DEPTH  = FACE_COUNT * TEX_SIZE * TEX_SIZE;
   localparam int unsigned DW     = TW + 17;
   localparam int unsigned CW     = $clog2(DW);

   logic [23:0] tex_mem [DEPTH];
   logic [23:0] mem_rd_ff;

   state_type   state_ff, state_in;
   logic [10:0] window_ff, window_in;
   logic [1:0]  face_ff, face_in;
   logic [TW-1:0] column_ff, column_in;
   logic [31:0] step_ff, step_in;
   logic [31:0] position_ff, position_in;
   logic [10:0] row_ff, row_in;
   logic [10:0] end_ff, end_in;
   logic [11:0] scol_ff, scol_in;
   logic [15:0] div_ff, div_in;
   logic [15:0] rem_ff, rem_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic signed [16:0] offset_ff, offset_in;

   logic        a_valid_ff, a_valid_in;
   logic [10:0] a_row_ff;
   logic [11:0] a_col_ff;
   logic        a_last_ff;
   logic        a_shade_ff;

   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff;

   logic        accept, load_fire, start_fire, pix_fire, span_live, adv;
   logic [TW-1:0] tex_row, frac_col;
   logic [ADDR_W-1:0] rd_addr, wr_addr;
   logic [AREA_W+11:0] load_wide;
   logic [16:0] div_r;
   logic        div_ge;
   logic [15:0] lh_fix;
   logic [31:0] off_ext;
   logic [11:0] row_next;
   logic [23:0] shaded;

   assign adv        = !rsp_valid_ff || rsp_ready;
   assign req_ready  = (state_ff == ST_IDLE) && (!a_valid_ff || adv);
   assign accept     = req_valid && req_ready;
   assign span_live  = row_ff < end_ff;
   assign load_fire  = accept && (req_data.command == CMD_LOAD);
   assign start_fire = accept && (req_data.command == CMD_START);
   assign pix_fire   = accept && (req_data.command == CMD_PIXEL) && span_live;
   assign csr_ready  = 1'b1;

   assign tex_row  = position_ff[16 +: TW] +
                     TW'(position_ff[31] && (position_ff[15:0] != 16'd0));
   assign rd_addr  = {face_ff, tex_row, column_ff};
   assign load_wide = {{AREA_W{1'b0}}, req_data.texel_address};
   assign wr_addr  = {req_data.face_select, load_wide[AREA_W-1:0]};
   assign frac_col = req_data.wall_fraction[15 -: TW];
   assign lh_fix   = (req_data.slice_height == 16'd0) ? 16'd1 : req_data.slice_height;
   assign div_r    = {rem_ff, (cnt_ff == CW'(DW - 1))};
   assign div_ge   = div_r >= {1'b0, div_ff};
   assign off_ext  = {{15{offset_ff[16]}}, offset_ff};
   assign row_next = {1'b0, row_ff} + 12'd1;
   assign shaded   = a_shade_ff ? ((mem_rd_ff >> 1) & SHADE_MASK) : mem_rd_ff;

   always_comb begin
      state_in    = state_ff;
      window_in   = window_ff;
      face_in     = face_ff;
      column_in   = column_ff;
      step_in     = step_ff;
      position_in = position_ff;
      row_in      = row_ff;
      end_in      = end_ff;
      scol_in     = scol_ff;
      div_in      = div_ff;
      rem_in      = rem_ff;
      cnt_in      = cnt_ff;
      offset_in   = offset_ff;

      if (csr_valid && csr_ready) begin
         window_in = csr_data;
      end

      case (state_ff)
         ST_IDLE: begin
            if (start_fire) begin
               if (!req_data.hit_side) begin
                  face_in = req_data.dir_x_negative ? FACE_WEST : FACE_EAST;
               end else begin
                  face_in = req_data.dir_y_positive ? FACE_SOUTH : FACE_NORTH;
               end
               if ((!req_data.hit_side && req_data.dir_x_negative) ||
                   (req_data.hit_side && req_data.dir_y_positive)) begin
                  column_in = ~frac_col;
               end else begin
                  column_in = frac_col;
               end
               div_in    = lh_fix;
               rem_in    = 16'd0;
               step_in   = 32'd0;
               cnt_in    = CW'(DW - 1);
               offset_in = $signed({6'd0, req_data.span_first})
                         - $signed({7'd0, window_ff[10:1]})
                         + $signed({2'd0, lh_fix[15:1]});
               row_in    = req_data.span_first;
               end_in    = req_data.span_stop;
               scol_in   = req_data.screen_column;
               state_in  = ST_DIVIDE;
            end else if (pix_fire) begin
               position_in = position_ff + step_ff;
               row_in      = row_next[10:0];
            end
         end
         ST_DIVIDE: begin
            rem_in  = div_ge ? 16'(div_r - {1'b0, div_ff}) : div_r[15:0];
            step_in = {step_ff[30:0], div_ge};
            cnt_in  = cnt_ff - CW'(1);
            if (cnt_ff == '0) begin
               state_in = ST_MULT;
            end
         end
         ST_MULT: begin
            position_in = off_ext * step_ff;
            state_in    = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      a_valid_in = a_valid_ff;
      if (pix_fire) begin
         a_valid_in = 1'b1;
      end else if (adv) begin
         a_valid_in = 1'b0;
      end
      rsp_valid_in = adv ? a_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (load_fire) begin
         tex_mem[wr_addr] <= req_data.texel_color;
      end
      if (pix_fire) begin
         mem_rd_ff <= tex_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         window_ff    <= WINDOW_DEFAULT;
         face_ff      <= FACE_NORTH;
         column_ff    <= '0;
         step_ff      <= 32'd0;
         position_ff  <= 32'd0;
         row_ff       <= 11'd0;
         end_ff       <= 11'd0;
         scol_ff      <= 12'd0;
         cnt_ff       <= '0;
         a_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         window_ff    <= window_in;
         face_ff      <= face_in;
         column_ff    <= column_in;
         step_ff      <= step_in;
         position_ff  <= position_in;
         row_ff       <= row_in;
         end_ff       <= end_in;
         scol_ff      <= scol_in;
         cnt_ff       <= cnt_in;
         a_valid_ff   <= a_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      div_ff    <= div_in;
      rem_ff    <= rem_in;
      offset_ff <= offset_in;
      if (pix_fire) begin
         a_row_ff   <= row_ff;
         a_col_ff   <= scol_ff;
         a_last_ff  <= (row_next == {1'b0, end_ff});
         a_shade_ff <= (face_ff == FACE_NORTH) || (face_ff == FACE_EAST);
      end
      if (adv && a_valid_ff) begin
         rsp_ff.pixel_row    <= a_row_ff;
         rsp_ff.pixel_column <= a_col_ff;
         rsp_ff.pixel_color  <= shaded;
         rsp_ff.write_enable <= (shaded != 24'd0);
         rsp_ff.last_pixel   <= a_last_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `WTCM_ASSERT_IMP(a_busy_blocks_req, clock, reset, state_ff != ST_IDLE, !req_ready)
   `WTCM_ASSERT_NXT(a_div_to_mult, clock, reset,
      (state_ff == ST_DIVIDE) && (cnt_ff == '0), state_ff == ST_MULT)
   `WTCM_ASSERT_NXT(a_pixel_reads, clock, reset, pix_fire, a_valid_ff)
   `WTCM_ASSERT_NXT(a_stage_moves, clock, reset,
      a_valid_ff && adv && !pix_fire, rsp_valid_ff && !a_valid_ff)

endmodule

FILE: sim/tb_wall_texture_column_mapper_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_wall_texture_column_mapper_top
// Self-checking bench for the wall texture column mapper. A predictor tracks
// texture memory, face, column, Q16.16 step and position, and the row span.
// It works out each pixel word from the accepted request words. Random columns
// with random content run under several sender and receiver idle mixes and
// several window heights. A pixel that would read an unloaded texel is always
// preceded by a load of that texel.
// ---------------------------------------------------------------------------
module tb_wall_texture_column_mapper_top;
   import wtcm_pkg::*;

   localparam int unsigned TEX_SIZE       = 64;
   localparam int unsigned TEX_AREA       = TEX_SIZE * TEX_SIZE;
   localparam logic [1:0]  CMD_UNUSED     = 2'd3;
   localparam int          SETTLE_CYCLES  = 64;
   localparam int          WATCHDOG_LIMIT = 5000;
   localparam int          PHASE_WORDS    = 220;
   localparam int          REPORT_LIMIT   = 10;

   class column_pixel_predictor;
      logic [23:0] texels [FACE_COUNT * TEX_AREA];
      bit          loaded [FACE_COUNT * TEX_AREA];
      logic [1:0]  face;
      int unsigned tex_col;
      logic [31:0] step_q16;
      logic [31:0] pos_q16;
      logic [10:0] row;
      logic [10:0] stop_row;
      logic [11:0] column;
      logic [10:0] window;
      rsp_type     pixels_due [$];
      int          mismatch_count;

      function new();
         face           = FACE_NORTH;
         tex_col        = 0;
         step_q16       = '0;
         pos_q16        = '0;
         row            = '0;
         stop_row       = '0;
         column         = '0;
         window         = WINDOW_DEFAULT;
         mismatch_count = 0;
      endfunction

      // integer part truncated toward zero, then wrapped to the texture
      function int unsigned texel_index();
         logic [31:0] whole;
         if (pos_q16[31]) begin
            whole = -((-pos_q16) >> 16);
         end else begin
            whole = pos_q16 >> 16;
         end
         return int'(face) * TEX_AREA + (whole & (TEX_SIZE - 1)) * TEX_SIZE + tex_col;
      endfunction

      function bit needs_texel(output int unsigned idx);
         idx = 0;
         if (row >= stop_row) begin
            return 1'b0;
         end
         idx = texel_index();
         return !loaded[idx];
      endfunction

      function void note_word(req_type w);
         int unsigned idx;
         logic [31:0] frac_col;
         logic [31:0] height;
         logic [31:0] offset;
         logic [23:0] color;
         rsp_type     pix;
         case (w.command)
            CMD_LOAD: begin
               idx = int'(w.face_select) * TEX_AREA + (int'(w.texel_address) & (TEX_AREA - 1));
               texels[idx] = w.texel_color;
               loaded[idx] = 1'b1;
            end
            CMD_START: begin
               if (!w.hit_side) begin
                  face = w.dir_x_negative ? FACE_WEST : FACE_EAST;
               end else begin
                  face = w.dir_y_positive ? FACE_SOUTH : FACE_NORTH;
               end
               frac_col = (32'(w.wall_fraction) * TEX_SIZE) >> 16;
               if (face == FACE_WEST || face == FACE_SOUTH) begin
                  frac_col = TEX_SIZE - 1 - frac_col;
               end
               tex_col  = frac_col & (TEX_SIZE - 1);
               height   = (w.slice_height == 16'd0) ? 32'd1 : 32'(w.slice_height);
               step_q16 = (32'(TEX_SIZE) << 16) / height;
               offset   = 32'(w.span_first) - 32'(window >> 1) + (height >> 1);
               pos_q16  = offset * step_q16;
               row      = w.span_first;
               stop_row = w.span_stop;
               column   = w.screen_column;
            end
            CMD_PIXEL: begin
               if (row < stop_row) begin
                  color   = texels[texel_index()];
                  pos_q16 = pos_q16 + step_q16;
                  if (face == FACE_NORTH || face == FACE_EAST) begin
                     color = (color >> 1) & SHADE_MASK;
                  end
                  pix.pixel_row    = row;
                  pix.pixel_column = column;
                  pix.pixel_color  = color;
                  pix.write_enable = (color != 24'd0);
                  pix.last_pixel   = (12'(row) + 12'd1 == 12'(stop_row));
                  pixels_due.push_back(pix);
                  row = row + 11'd1;
               end
            end
            default: ;
         endcase
      endfunction

      function void check_pixel(rsp_type got);
         rsp_type want;
         bit      bad;
         if (pixels_due.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
               $display("unexpected pixel word: row %0d col %0d color %06h we %0b last %0b",
                        got.pixel_row, got.pixel_column, got.pixel_color,
                        got.write_enable, got.last_pixel);
            end
            return;
         end
         want = pixels_due.pop_front();
         bad  = (got.pixel_row !== want.pixel_row) || (got.pixel_column !== want.pixel_column)
             || (got.pixel_color !== want.pixel_color)
             || (got.write_enable !== want.write_enable)
             || (got.last_pixel !== want.last_pixel);
         if (bad) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
               $display("pixel mismatch: want row %0d col %0d color %06h we %0b last %0b",
                        want.pixel_row, want.pixel_column, want.pixel_color,
                        want.write_enable, want.last_pixel);
               $display("                got  row %0d col %0d color %06h we %0b last %0b",
                        got.pixel_row, got.pixel_column, got.pixel_color,
                        got.write_enable, got.last_pixel);
            end
         end
      endfunction
   endclass

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data  = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [10:0] csr_data  = '0;

   column_pixel_predictor pixel_pred = new();
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int rsp_hold_want = 0;
   int words_sent    = 0;

   wall_texture_column_mapper_top #(
      .TEX_SIZE(TEX_SIZE)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data (csr_data)
   );

   always #4 clock = ~clock;

   // receiver: checks pixel words, stalls at random, long hold-off on request
   always @(posedge clock) begin : receiver
      int hold_left;
      if (!reset && rsp_valid && rsp_ready) begin
         pixel_pred.check_pixel(rsp_data);
      end
      if (rsp_hold_want > 0) begin
         hold_left     = rsp_hold_want;
         rsp_hold_want = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= (int'($urandom_range(0, 99)) >= rsp_stall_pct);
      end
   end

   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
      $display("** wall_texture_column_mapper_top: FAILED **");
      $finish;
   end

   function automatic req_type rand_word();
      logic [127:0] bits;
      bits = {$urandom(), $urandom(), $urandom(), $urandom()};
      return bits[$bits(req_type)-1:0];
   endfunction

   function automatic logic [23:0] rand_color();
      case ($urandom_range(0, 7))
         0: return 24'h000000;
         1: return 24'h000001;
         2: return 24'hFFFFFF;
         3: return 24'h010101;
         default: return 24'($urandom());
      endcase
   endfunction

   function automatic req_type make_start(logic side, logic xneg, logic ypos,
                                          logic [15:0] frac, logic [15:0] height,
                                          logic [10:0] first, logic [10:0] stop,
                                          logic [11:0] scol);
      req_type w;
      w                = rand_word();
      w.command        = CMD_START;
      w.hit_side       = side;
      w.dir_x_negative = xneg;
      w.dir_y_positive = ypos;
      w.wall_fraction  = frac;
      w.slice_height   = height;
      w.span_first     = first;
      w.span_stop      = stop;
      w.screen_column  = scol;
      return w;
   endfunction

   function automatic req_type make_word(logic [1:0] cmd);
      req_type w;
      w         = rand_word();
      w.command = cmd;
      return w;
   endfunction

   task automatic push_word(req_type w);
      while (int'($urandom_range(0, 99)) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (!req_ready);
      pixel_pred.note_word(w);
      if (w.command != CMD_UNUSED) begin
         words_sent++;
      end
   endtask

   // a pixel never reads a texel that was not loaded
   task automatic send_word(req_type w);
      int unsigned idx;
      req_type     fill;
      if (w.command == CMD_PIXEL && pixel_pred.needs_texel(idx)) begin
         fill               = make_word(CMD_LOAD);
         fill.face_select   = 2'(idx / TEX_AREA);
         fill.texel_address = 12'(idx % TEX_AREA);
         fill.texel_color   = rand_color();
         push_word(fill);
      end
      push_word(w);
   endtask

   task automatic send_load(logic [1:0] face, logic [11:0] addr, logic [23:0] color);
      req_type w;
      w               = make_word(CMD_LOAD);
      w.face_select   = face;
      w.texel_address = addr;
      w.texel_color   = color;
      send_word(w);
   endtask

   task automatic send_pixels(int count);
      repeat (count) send_word(make_word(CMD_PIXEL));
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pixel_pred.pixels_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_window(logic [10:0] height);
      csr_valid <= 1'b1;
      csr_data  <= height;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      pixel_pred.window = height;
   endtask

   task automatic random_column(int long_pct);
      req_type     w;
      int unsigned span;
      int unsigned count;
      int unsigned pick;
      w = rand_word();
      if ($urandom_range(0, 99) < 15) begin
         w.command = 2'($urandom_range(0, 3));
         if (w.command == CMD_LOAD) begin
            w.texel_color = rand_color();
         end
         send_word(w);
         return;
      end
      w.command = CMD_START;
      case ($urandom_range(0, 9))
         0: w.slice_height = 16'($urandom_range(0, 2));
         1: w.slice_height = 16'(65535 - $urandom_range(0, 3));
         2, 3: w.slice_height = 16'($urandom());
         default: w.slice_height = 16'($urandom_range(2, 700));
      endcase
      if (int'($urandom_range(0, 99)) < long_pct) begin
         span = $urandom_range(25, 160);
      end else begin
         span = $urandom_range(0, 24);
      end
      w.span_first = 11'($urandom_range(0, 2047));
      if ($urandom_range(0, 9) == 0) begin
         w.span_stop = 11'($urandom());
      end else begin
         w.span_stop = (w.span_first + span > 2047) ? 11'd2047 : 11'(w.span_first + span);
      end
      send_word(w);
      count = (w.span_stop > w.span_first) ? int'(w.span_stop - w.span_first) : 0;
      count = count + $urandom_range(0, 2);
      repeat (count) begin
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            send_load(2'($urandom()), 12'($urandom()), rand_color());
         end else if (pick < 11) begin
            send_word(make_word(CMD_UNUSED));
         end
         send_word(make_word(CMD_PIXEL));
      end
   endtask

   initial begin : stimulus
      int send_mix [4];
      int recv_mix [4];
      logic [10:0] heights [4];
      int target;
      send_mix = '{0, 66, 0, 7};
      recv_mix = '{0, 0, 66, 7};
      heights  = '{11'd1, 11'd2047, 11'($urandom_range(1, 2047)), 11'($urandom_range(1, 2047))};

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset window height, no span, unused code, each face
      send_pixels(1);
      send_word(make_word(CMD_UNUSED));
      send_load(FACE_NORTH, 12'd0, 24'h000000);
      send_load(FACE_EAST, 12'd4095, 24'hFFFFFF);
      send_word(make_start(1'b1, 1'b0, 1'b0, 16'h0000, 16'd64, 11'd208, 11'd210, 12'd0));
      send_pixels(3);
      send_word(make_start(1'b0, 1'b0, 1'b1, 16'hFFFF, 16'd64, 11'd207, 11'd208, 12'd4095));
      send_pixels(1);
      send_word(make_start(1'b0, 1'b1, 1'b0, 16'h0000, 16'd0, 11'd0, 11'd3, 12'd1234));
      send_pixels(3);
      send_word(make_start(1'b1, 1'b1, 1'b1, 16'h8000, 16'hFFFF, 11'd2046, 11'd2047, 12'd0));
      send_pixels(1);
      send_word(make_start(1'b1, 1'b0, 1'b1, 16'h1234, 16'd100, 11'd5, 11'd5, 12'd7));
      send_pixels(1);
      send_word(make_start(1'b0, 1'b1, 1'b0, 16'h4321, 16'd100, 11'd9, 11'd3, 12'd8));
      send_pixels(1);

      for (int p = 0; p < 4; p++) begin
         wait_idle();
         write_window(heights[p]);
         send_idle_pct = send_mix[p];
         rsp_stall_pct = recv_mix[p];
         target = words_sent + PHASE_WORDS;
         while (words_sent < target) random_column(5);
      end

      // back-pressure: receiver holds off while a long span is offered
      wait_idle();
      write_window(WINDOW_DEFAULT);
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      rsp_hold_want = 400;
      send_word(make_start(1'b0, 1'b0, 1'b0, 16'($urandom()), 16'd150, 11'd300, 11'd420,
                           12'($urandom())));
      send_pixels(120);
      send_idle_pct = 7;
      rsp_stall_pct = 7;
      target = words_sent + PHASE_WORDS / 2;
      while (words_sent < target) random_column(20);

      wait_idle();
      if (pixel_pred.mismatch_count == 0 && pixel_pred.pixels_due.size() == 0) begin
         $display("** wall_texture_column_mapper_top: PASSED **");
      end else begin
         $display("** wall_texture_column_mapper_top: FAILED **");
      end
      $finish;
   end

endmodule
